[rtl/elr_pkg.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared constants for the output format and the request kinds.
// ----------------------------------------------------------------------------
package elr_pkg;

  // Width of each output pixel coordinate.
  localparam int OUT_BITS = 13;

  // Output tdata width: two coordinates packed and padded to whole bytes.
  localparam int OUT_TW = ((2 * OUT_BITS + 7) / 8) * 8;

  // Request kinds carried on the input tuser.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

endpackage

[rtl/elr_mul.sv]
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed W x W multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module elr_mul #(
  parameter int W = 25
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[rtl/elr_emit.sv]
// ----------------------------------------------------------------------------
// Pixel emitter
// Holds one point and sends its four mirrored pixels, one per request.
// ----------------------------------------------------------------------------
module elr_emit #(
  parameter int XW         = 11,
  parameter int YW         = 12,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic        [XW-1:0]         pt_x,
  input  logic signed [YW-1:0]         pt_y,
  input  logic signed [COORD_BITS-1:0] org_x,
  input  logic signed [COORD_BITS-1:0] org_y,
  input  logic                         pt_fin,
  output logic                         free,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [elr_pkg::OUT_TW-1:0]   m_tdata,  // pixel_x, pixel_y
  output logic                         m_tlast,
  output logic                         m_tuser   // done_res
);

  localparam int SW0   = (COORD_BITS > YW) ? COORD_BITS + 1 : YW + 1;
  localparam int SUM_W = (SW0 > elr_pkg::OUT_BITS) ? SW0 : elr_pkg::OUT_BITS;

  logic                         busy;
  logic [1:0]                   idx;
  logic        [XW-1:0]         px;
  logic signed [YW-1:0]         py;
  logic signed [COORD_BITS-1:0] ox;
  logic signed [COORD_BITS-1:0] oy;
  logic                         fin;

  logic                     take;
  logic signed [SUM_W-1:0]  px_e, py_e, ox_e, oy_e, sx, sy;

  assign take = busy && m_tready;
  assign free = !busy || (take && idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load && free) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
      if (idx == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      px  <= pt_x;
      py  <= pt_y;
      ox  <= org_x;
      oy  <= org_y;
      fin <= pt_fin;
    end
  end

  // Pixel order: (+x,+y), (-x,+y), (+x,-y), (-x,-y); sums wrap to the output width.
  always_comb begin
    px_e = $signed(SUM_W'(px));
    py_e = SUM_W'(py);
    ox_e = SUM_W'(ox);
    oy_e = SUM_W'(oy);
    sx   = idx[0] ? (ox_e - px_e) : (ox_e + px_e);
    sy   = idx[1] ? (oy_e - py_e) : (oy_e + py_e);
  end

  assign m_tvalid = busy;
  assign m_tdata  = elr_pkg::OUT_TW'({sy[elr_pkg::OUT_BITS-1:0], sx[elr_pkg::OUT_BITS-1:0]});
  assign m_tlast  = (idx == 2'd3);
  assign m_tuser  = fin;

endmodule

[rtl/midpoint_ellipse_rasterizer_top.sv]
// Start request: ready again after S_SQX, S_SQY, S_DY, S_DINIT and S_CHK, or also
// after S_E1 to S_E6 when it begins directly in region 2 (five use the multiplier).
// Step request: first pixel in the cycle after acceptance, then one pixel per
// cycle while m_tready is high; a new step waits for the single pixel port.
// A step into region 2 also runs S_E1 to S_E6 before the next request is taken.
// Synchronous active-high rst: no ellipse active, sequencer idle, no pixel pending.
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Two-region integer midpoint ellipse with a shared multiplier under a
// small sequencer and a four-pixel output emitter.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  // center_x, center_y, radius_x, radius_y
  input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                                            s_tuser,   // func
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  output logic [elr_pkg::OUT_TW-1:0]                      m_tdata,   // pixel_x, pixel_y
  output logic                                            m_tlast,
  output logic                                            m_tuser    // done_res
);

  localparam int R     = RADIUS_BITS;
  localparam int C     = COORD_BITS;
  localparam int XW    = R + 1;
  localparam int YW    = R + 2;
  localparam int SQ_W  = 2 * R;
  localparam int DX_W  = 3 * R + 4;
  localparam int DEC_W = 4 * R + 8;
  localparam int MUL_W = 2 * R + 5;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SQX   = 12'b0000_0000_0010,
    S_SQY   = 12'b0000_0000_0100,
    S_DY    = 12'b0000_0000_1000,
    S_DINIT = 12'b0000_0001_0000,
    S_CHK   = 12'b0000_0010_0000,
    S_E1    = 12'b0000_0100_0000,
    S_E2    = 12'b0000_1000_0000,
    S_E3    = 12'b0001_0000_0000,
    S_E4    = 12'b0010_0000_0000,
    S_E5    = 12'b0100_0000_0000,
    S_E6    = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic                    active;
  logic                    in_r2;
  logic        [XW-1:0]    cur_x;
  logic signed [YW-1:0]    cur_y;
  logic signed [C-1:0]     orig_x;
  logic signed [C-1:0]     orig_y;
  logic        [R-1:0]     rad_x;
  logic        [SQ_W-1:0]  rx2;
  logic        [SQ_W-1:0]  ry2;
  logic signed [DX_W-1:0]  step_dx;
  logic signed [DX_W-1:0]  step_dy;
  logic signed [DEC_W-1:0] decision;

  logic signed [C-1:0] in_cx, in_cy;
  logic        [R-1:0] in_rx, in_ry;
  logic                acc, start_acc, step_acc;
  logic                emit_free;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [DEC_W-1:0]   mul_dec;
  logic signed [YW:0]        y_m1;

  logic signed [DX_W-1:0]  rx2_dx, ry2_dx, dx_inc, dy_dec;
  logic signed [DEC_W-1:0] rx2_dec, ry2_dec;
  logic        [XW-1:0]    x_n;
  logic signed [YW-1:0]    y_n;
  logic signed [DX_W-1:0]  dx_n, dy_n;
  logic signed [DEC_W-1:0] dec_n;
  logic                    fin_n;

  assign in_cx = s_tdata[C-1:0];
  assign in_cy = s_tdata[2*C-1:C];
  assign in_rx = s_tdata[2*C+R-1:2*C];
  assign in_ry = s_tdata[2*C+2*R-1:2*C+R];

  assign s_tready  = (state == S_IDLE) && emit_free;
  assign acc       = s_tvalid && s_tready;
  assign start_acc = acc && (s_tuser == elr_pkg::FUNC_START);
  assign step_acc  = acc && (s_tuser == elr_pkg::FUNC_STEP) && active;

  assign rx2_dx  = $signed(DX_W'({rx2, 1'b0}));
  assign ry2_dx  = $signed(DX_W'({ry2, 1'b0}));
  assign rx2_dec = $signed(DEC_W'(rx2));
  assign ry2_dec = $signed(DEC_W'(ry2));
  assign mul_dec = $signed(mul_p[DEC_W-1:0]);
  assign y_m1    = (YW+1)'(cur_y) - (YW+1)'(1);

  // Operand selection for the shared multiplier; each product is read in the state after the one that selects it.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = $signed(MUL_W'(rad_x));
        mul_b = $signed(MUL_W'(rad_x));
      end
      S_SQY: begin
        mul_a = MUL_W'(cur_y);
        mul_b = MUL_W'(cur_y);
      end
      S_DY: begin
        mul_a = $signed(MUL_W'(rx2));
        mul_b = MUL_W'(cur_y);
      end
      S_E1: begin
        mul_a = $signed(MUL_W'({cur_x, 1'b1}));
        mul_b = $signed(MUL_W'({cur_x, 1'b1}));
      end
      S_E2: begin
        mul_a = $signed(MUL_W'(ry2));
        mul_b = $signed(mul_p[MUL_W-1:0]);
      end
      S_E3: begin
        mul_a = MUL_W'(y_m1);
        mul_b = MUL_W'(y_m1);
      end
      S_E4: begin
        mul_a = $signed(MUL_W'(rx2));
        mul_b = $signed(mul_p[MUL_W-1:0]);
      end
      S_E5: begin
        mul_a = $signed(MUL_W'(rx2));
        mul_b = $signed(MUL_W'(ry2));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  elr_mul #(
    .W (MUL_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // One midpoint step; decision terms are kept at four times their real value.
  always_comb begin
    x_n    = cur_x;
    y_n    = cur_y;
    dx_n   = step_dx;
    dy_n   = step_dy;
    dec_n  = decision;
    dx_inc = step_dx + ry2_dx;
    dy_dec = step_dy - rx2_dx;
    if (!in_r2) begin
      x_n  = cur_x + 1'b1;
      dx_n = dx_inc;
      if (decision[DEC_W-1]) begin
        dec_n = decision + ((DEC_W'(dx_inc) + ry2_dec) <<< 2);
      end else begin
        y_n   = cur_y - 1'b1;
        dy_n  = dy_dec;
        dec_n = decision + ((DEC_W'(dx_inc) - DEC_W'(dy_dec) + ry2_dec) <<< 2);
      end
    end else begin
      y_n  = cur_y - 1'b1;
      dy_n = dy_dec;
      if (!decision[DEC_W-1] && decision != '0) begin
        dec_n = decision + ((rx2_dec - DEC_W'(dy_dec)) <<< 2);
      end else begin
        x_n   = cur_x + 1'b1;
        dx_n  = dx_inc;
        dec_n = decision + ((DEC_W'(dx_inc) - DEC_W'(dy_dec) + rx2_dec) <<< 2);
      end
    end
    fin_n = (in_r2 || !(dx_n < dy_n)) && y_n[YW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      active <= 1'b0;
      in_r2  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start_acc) begin
            active <= 1'b1;
            in_r2  <= 1'b0;
            state  <= S_SQX;
          end else if (step_acc) begin
            if (fin_n) begin
              active <= 1'b0;
            end
            state <= S_CHK;
          end
        end
        S_SQX:   state <= S_SQY;
        S_SQY:   state <= S_DY;
        S_DY:    state <= S_DINIT;
        S_DINIT: state <= S_CHK;
        S_CHK: begin
          if (!in_r2 && !(step_dx < step_dy)) begin
            state <= S_E1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_E1: state <= S_E2;
        S_E2: state <= S_E3;
        S_E3: state <= S_E4;
        S_E4: state <= S_E5;
        S_E5: state <= S_E6;
        S_E6: begin
          in_r2 <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start_acc) begin
          orig_x  <= in_cx;
          orig_y  <= in_cy;
          rad_x   <= in_rx;
          cur_x   <= '0;
          cur_y   <= $signed(YW'(in_ry));
          step_dx <= '0;
        end else if (step_acc) begin
          cur_x    <= x_n;
          cur_y    <= y_n;
          step_dx  <= dx_n;
          step_dy  <= dy_n;
          decision <= dec_n;
        end
      end
      S_SQY: rx2 <= mul_p[SQ_W-1:0];
      S_DY:  ry2 <= mul_p[SQ_W-1:0];
      S_DINIT: begin
        step_dy  <= $signed({mul_p[DX_W-2:0], 1'b0});
        decision <= (ry2_dec <<< 2) - (mul_dec <<< 2) + rx2_dec;
      end
      S_E3: decision <= mul_dec;
      S_E5: decision <= decision + (mul_dec <<< 2);
      S_E6: decision <= decision - (mul_dec <<< 2);
      default: begin
      end
    endcase
  end

  elr_emit #(
    .XW         (XW),
    .YW         (YW),
    .COORD_BITS (C)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (step_acc),
    .pt_x     (cur_x),
    .pt_y     (cur_y),
    .org_x    (orig_x),
    .org_y    (orig_y),
    .pt_fin   (fin_n),
    .free     (emit_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // A step on an active ellipse always produces pixels on the next cycle.
  a_step_emits: assert property (@(posedge clk) disable iff (rst)
    step_acc |=> m_tvalid)
    else $error("step request did not start pixel output");

  // The final point retires the ellipse.
  a_fin_retires: assert property (@(posedge clk) disable iff (rst)
    step_acc && fin_n |=> !active)
    else $error("ellipse still active after final point");

  // Region 2 is left only through a new start request.
  a_region_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_r2) |-> $past(start_acc))
    else $error("region 2 left without a start request");

  // The four pixels of a point leave without gaps in validity.
  a_point_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("pixel burst broken before the fourth pixel");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer testbench
// Streams start and step requests into the rasterizer and checks every pixel
// against an internal prediction of the two-region midpoint walk. Idling on
// both sides varies by phase, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_BITS    = elr_pkg::OUT_BITS;
  localparam int OUT_TW      = elr_pkg::OUT_TW;
  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 12;
  localparam int IN_TW       = ((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic                          func;
    logic signed [COORD_BITS-1:0]  cx;
    logic signed [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0]        rx;
    logic [RADIUS_BITS-1:0]        ry;
  } ellipse_req_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] px;
    logic signed [OUT_BITS-1:0] py;
    logic                       last;
    logic                       done;
  } pixel_t;

  logic              clk;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_TW-1:0]  s_tdata  = '0;
  logic              s_tuser  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  ellipse_req_t req_q[$];
  pixel_t       pixel_q[$];
  ellipse_req_t drv_req;
  pixel_t       want;
  int           errors = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic         hold_req = 1'b0;
  logic         hold_taken;
  int           hold_left;

  // Predicted rasterizer state.
  bit     e_active;
  bit     e_region_two;
  longint e_x, e_y, e_org_x, e_org_y, e_rx2, e_ry2, e_dx, e_dy, e_dec;

  midpoint_ellipse_rasterizer_top #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void enter_region_two();
    longint a;
    longint b;
    if (!e_region_two && !(e_dx < e_dy)) begin
      a = 2 * e_x + 1;
      b = e_y - 1;
      e_region_two = 1'b1;
      e_dec = e_ry2 * a * a + 4 * e_rx2 * b * b - 4 * e_rx2 * e_ry2;
    end
  endfunction

  // Advances the predicted walk by one request and queues the pixels it emits.
  function automatic void predict_pixels(ellipse_req_t r);
    longint px;
    longint py;
    longint rxv;
    longint ryv;
    bit     fin;
    pixel_t p;
    px = e_x;
    py = e_y;
    if (r.func == elr_pkg::FUNC_START) begin
      rxv = longint'(r.rx);
      ryv = longint'(r.ry);
      e_org_x = longint'(r.cx);
      e_org_y = longint'(r.cy);
      e_rx2 = rxv * rxv;
      e_ry2 = ryv * ryv;
      e_x = 0;
      e_y = ryv;
      e_dx = 0;
      e_dy = 2 * e_rx2 * ryv;
      e_dec = 4 * e_ry2 - 4 * e_rx2 * ryv + e_rx2;
      e_region_two = 1'b0;
      e_active = 1'b1;
      enter_region_two();
      return;
    end
    if (!e_active) return;
    if (!e_region_two) begin
      e_x += 1;
      e_dx += 2 * e_ry2;
      if (e_dec < 0) begin
        e_dec += 4 * (e_dx + e_ry2);
      end else begin
        e_y -= 1;
        e_dy -= 2 * e_rx2;
        e_dec += 4 * (e_dx - e_dy + e_ry2);
      end
      enter_region_two();
    end else begin
      e_y -= 1;
      e_dy -= 2 * e_rx2;
      if (e_dec > 0) begin
        e_dec += 4 * (e_rx2 - e_dy);
      end else begin
        e_x += 1;
        e_dx += 2 * e_ry2;
        e_dec += 4 * (e_dx - e_dy + e_rx2);
      end
    end
    fin = e_region_two && (e_y < 0);
    if (fin) e_active = 1'b0;
    for (int k = 0; k < 4; k++) begin
      p.px   = OUT_BITS'(e_org_x + (((k & 1) != 0) ? -px : px));
      p.py   = OUT_BITS'(e_org_y + (((k & 2) != 0) ? -py : py));
      p.last = (k == 3);
      p.done = fin;
      pixel_q.push_back(p);
    end
  endfunction

  // Driver: presents queued requests and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_pixels(drv_req);
      if (!s_tvalid || s_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= IN_TW'({drv_req.ry, drv_req.rx, drv_req.cy, drv_req.cx});
          s_tuser  <= drv_req.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off, started once on request from the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compares each accepted pixel with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel (%0d,%0d) arrived with none expected",
                 $signed(m_tdata[OUT_BITS-1:0]), $signed(m_tdata[2*OUT_BITS-1:OUT_BITS]));
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (m_tdata[OUT_BITS-1:0] !== want.px) begin
            $error("pixel_x expected %0d got %0d", want.px, $signed(m_tdata[OUT_BITS-1:0]));
            errors++;
          end
          if (m_tdata[2*OUT_BITS-1:OUT_BITS] !== want.py) begin
            $error("pixel_y expected %0d got %0d", want.py,
                   $signed(m_tdata[2*OUT_BITS-1:OUT_BITS]));
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last expected %0b got %0b", want.last, m_tlast);
            errors++;
          end
          if (m_tuser !== want.done) begin
            $error("done_res expected %0b got %0b", want.done, m_tuser);
            errors++;
          end
        end
      end
      m_tready <= (hold_left > 0) ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void push_start(logic signed [COORD_BITS-1:0] cx,
                                     logic signed [COORD_BITS-1:0] cy,
                                     logic [RADIUS_BITS-1:0] rx,
                                     logic [RADIUS_BITS-1:0] ry);
    ellipse_req_t r;
    r.func = elr_pkg::FUNC_START;
    r.cx = cx;
    r.cy = cy;
    r.rx = rx;
    r.ry = ry;
    req_q.push_back(r);
  endfunction

  // Step requests carry random junk in the fields the block ignores.
  function automatic void push_steps(int n);
    ellipse_req_t r;
    for (int i = 0; i < n; i++) begin
      r.func = elr_pkg::FUNC_STEP;
      r.cx = COORD_BITS'($urandom);
      r.cy = COORD_BITS'($urandom);
      r.rx = RADIUS_BITS'($urandom);
      r.ry = RADIUS_BITS'($urandom);
      req_q.push_back(r);
    end
  endfunction

  // Mostly complete small ellipses, with some large abandoned ones, broken
  // sequences and stray steps mixed in.
  function automatic void queue_random_ellipses(int n);
    int sent;
    int kind;
    int rxv;
    int ryv;
    int nsteps;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 95) begin
        if (kind >= 75 && kind < 87) begin
          rxv = $urandom_range(1023);
          ryv = $urandom_range(1023);
          nsteps = $urandom_range(1, 8);
        end else begin
          rxv = $urandom_range(12);
          ryv = $urandom_range(12);
          nsteps = (kind < 75) ? rxv + ryv + 1 + $urandom_range(2) : $urandom_range(4);
        end
        push_start(COORD_BITS'($urandom), COORD_BITS'($urandom),
                   RADIUS_BITS'(rxv), RADIUS_BITS'(ryv));
        sent++;
      end else begin
        nsteps = $urandom_range(1, 3);
      end
      push_steps(nsteps);
      sent += nsteps;
    end
  endfunction

  task automatic run_phase(int idle_pct, int stall, int n, bit hold);
    @(negedge clk);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    if (hold) hold_req = 1'b1;
    queue_random_ellipses(n);
    while (req_q.size() > 0 || s_tvalid) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Step before any start, then degenerate and extreme ellipses.
    push_steps(1);
    push_start(12'sd0, 12'sd0, 10'd0, 10'd0);
    push_steps(2);
    push_start(12'sd2047, -12'sd2048, 10'd0, 10'd3);
    push_steps(5);
    push_start(-12'sd2048, 12'sd2047, 10'd3, 10'd0);
    push_steps(5);
    push_start(-12'sd1, 12'sd1, 10'd1023, 10'd1023);
    push_steps(3);
    // A new start abandons the large ellipse in mid-walk.
    push_start(12'sd100, -12'sd100, 10'd2, 10'd1);
    push_steps(5);
    while (req_q.size() > 0 || s_tvalid) @(negedge clk);

    run_phase(0, 0, 70, 1'b1);
    run_phase(71, 0, 70, 1'b0);
    run_phase(0, 71, 70, 1'b0);
    run_phase(27, 27, 70, 1'b0);

    while (pixel_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
